// File: rtl/sbad_pkg.sv
// Shared types, constants and arithmetic helpers for the signed byte ALU.
// Used by every module of the block; depends on nothing.

package sbad_pkg;

    localparam int DATA_WIDTH   = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int OUTBUF_DEPTH = 2;
    localparam int OPTR_W       = $clog2(OUTBUF_DEPTH);
    localparam int INFLIGHT_MAX = QUEUE_DEPTH + DATA_WIDTH + OUTBUF_DEPTH;
    localparam int INFLIGHT_W   = $clog2(INFLIGHT_MAX + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;

    localparam word_t WORD_ONE = word_t'(1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                           operation;
        logic signed [DATA_WIDTH-1:0]  operand_a;
        logic signed [DATA_WIDTH-1:0]  operand_b;
    } alu_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  acc_result;
        logic        [DATA_WIDTH-1:0]  q_result;
        logic                          overflow_flag;
    } alu_out_t;

    // Work item passed from the front end through the queue and the step pipeline.
    typedef struct packed {
        op_t   op;
        word_t acc;       // Booth accumulator / partial remainder / add-sub result
        word_t q;         // Booth multiplier / dividend bits shifting into quotient
        logic  q1;        // Booth Q(-1)
        logic  ovf;
        word_t opb;       // multiplicand or divisor magnitude
        logic  neg_q;
        logic  neg_r;
        logic  div_zero;
    } work_t;

    function automatic word_t negate(word_t a);
        return ~a + WORD_ONE;
    endfunction

    // Returns {overflow, sum}; overflow is carry into sign XOR carry out.
    function automatic logic [DATA_WIDTH:0] add_ovf(word_t a, word_t b);
        logic [DATA_WIDTH-1:0] low;
        logic [DATA_WIDTH:0]   full;
        low  = {1'b0, a[DATA_WIDTH-2:0]} + {1'b0, b[DATA_WIDTH-2:0]};
        full = {1'b0, a} + {1'b0, b};
        return {low[DATA_WIDTH-1] ^ full[DATA_WIDTH], full[DATA_WIDTH-1:0]};
    endfunction

    function automatic logic [DATA_WIDTH:0] sub_ovf(word_t a, word_t b);
        return add_ovf(a, negate(b));
    endfunction

    // One Booth step or one restoring-divide step; add and subtract pass through.
    function automatic work_t work_step(work_t w);
        work_t               r;
        logic [DATA_WIDTH:0] sum;
        word_t               acc_new;
        word_t               rem_sh;
        logic [DATA_WIDTH:0] diff;
        r       = w;
        sum     = '0;
        acc_new = w.acc;
        rem_sh  = '0;
        diff    = '0;
        unique case (w.op)
            OP_ADD, OP_SUB:
            begin
                r = w;
            end
            OP_MUL:
            begin
                if (w.q1 && !w.q[0])
                begin
                    sum     = add_ovf(w.acc, w.opb);
                    acc_new = sum[DATA_WIDTH-1:0];
                    r.ovf   = sum[DATA_WIDTH];
                end
                else if (!w.q1 && w.q[0])
                begin
                    sum     = sub_ovf(w.acc, w.opb);
                    acc_new = sum[DATA_WIDTH-1:0];
                    r.ovf   = sum[DATA_WIDTH];
                end
                r.q1  = w.q[0];
                r.q   = {acc_new[0], w.q[DATA_WIDTH-1:1]};
                r.acc = {acc_new[DATA_WIDTH-1], acc_new[DATA_WIDTH-1:1]};
            end
            OP_DIV:
            begin
                rem_sh = {w.acc[DATA_WIDTH-2:0], w.q[DATA_WIDTH-1]};
                diff   = {1'b0, rem_sh} - {1'b0, w.opb};
                if (!diff[DATA_WIDTH])
                begin
                    r.acc = diff[DATA_WIDTH-1:0];
                    r.q   = {w.q[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    r.acc = rem_sh;
                    r.q   = {w.q[DATA_WIDTH-2:0], 1'b0};
                end
            end
            default:
            begin
                r = w;
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/sbad_front.sv
// Front end: accepts input items and classifies them into work items.
// Depends on sbad_pkg; add and subtract finish here.

module sbad_front
    import sbad_pkg::*;
(
    input  logic    push,
    input  logic    queue_full,
    input  alu_in_t item,
    output logic    wr_en,
    output work_t   work
);

    logic [DATA_WIDTH:0] sum;

    assign wr_en = push && !queue_full;

    always_comb
    begin
        work = '0;
        sum  = '0;
        work.op = item.operation;
        unique case (item.operation)
            OP_ADD:
            begin
                sum      = add_ovf(item.operand_a, item.operand_b);
                work.acc = sum[DATA_WIDTH-1:0];
                work.ovf = sum[DATA_WIDTH];
            end
            OP_SUB:
            begin
                sum      = sub_ovf(item.operand_a, item.operand_b);
                work.acc = sum[DATA_WIDTH-1:0];
                work.ovf = sum[DATA_WIDTH];
            end
            OP_MUL:
            begin
                work.q   = item.operand_a;
                work.opb = item.operand_b;
            end
            OP_DIV:
            begin
                // divide magnitudes, fix signs at the end
                work.q        = item.operand_a[DATA_WIDTH-1] ? negate(item.operand_a)
                                                             : item.operand_a;
                work.opb      = item.operand_b[DATA_WIDTH-1] ? negate(item.operand_b)
                                                             : item.operand_b;
                work.neg_q    = item.operand_a[DATA_WIDTH-1] ^ item.operand_b[DATA_WIDTH-1];
                work.neg_r    = item.operand_a[DATA_WIDTH-1];
                work.div_zero = (item.operand_b == '0);
            end
            default:
            begin
                work.op = item.operation;
            end
        endcase
    end

endmodule

// File: rtl/sbad_queue.sv
// Short queue of work items between the front end and the step pipeline.
// Depends on sbad_pkg for the work item type and depth.

module sbad_queue
    import sbad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  work_t wr_data,
    input  logic  rd_en,
    output work_t rd_data,
    output logic  full,
    output logic  empty
);

    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   QCNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    work_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == QCNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/sbad_back.sv
// Back end: step pipeline (one Booth or divide step per stage) and result buffer.
// Depends on sbad_pkg for work_step and the item types.

module sbad_back
    import sbad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  work_t    q_data,
    output logic     q_pop,
    input  logic     pop,
    output logic     empty,
    output alu_out_t result
);

    localparam logic [OPTR_W:0] OCNT_FULL = (OPTR_W + 1)'(OUTBUF_DEPTH);
    localparam logic [OPTR_W-1:0] OPTR_LAST = OPTR_W'(OUTBUF_DEPTH - 1);

    logic [DATA_WIDTH-1:0] valid_reg, valid_next;
    work_t                 work_reg  [DATA_WIDTH];
    work_t                 work_next [DATA_WIDTH];
    logic                  advance;

    alu_out_t              buf_mem [OUTBUF_DEPTH];
    logic [OPTR_W-1:0]     bwr_ptr_reg, bwr_ptr_next;
    logic [OPTR_W-1:0]     brd_ptr_reg, brd_ptr_next;
    logic [OPTR_W:0]       bcount_reg, bcount_next;
    logic                  buf_full, buf_wr, buf_rd;
    alu_out_t              finished;

    function automatic alu_out_t finish(work_t w);
        alu_out_t r;
        r = '0;
        unique case (w.op)
            OP_ADD, OP_SUB:
            begin
                r.acc_result    = w.acc;
                r.overflow_flag = w.ovf;
            end
            OP_MUL:
            begin
                r.acc_result    = w.acc;
                r.q_result      = w.q;
                r.overflow_flag = w.ovf;
            end
            OP_DIV:
            begin
                if (w.div_zero)
                begin
                    r.overflow_flag = 1'b1;
                end
                else
                begin
                    r.q_result   = w.neg_q ? negate(w.q) : w.q;
                    r.acc_result = w.neg_r ? negate(w.acc) : w.acc;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Whole pipeline moves together; it holds only while the result buffer is full.
    assign advance    = !buf_full;
    assign q_pop      = advance && !q_empty;
    assign valid_next = {valid_reg[DATA_WIDTH-2:0], !q_empty};

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            assign work_next[i] = work_step(q_data);
        end
        else
        begin : g_rest
            assign work_next[i] = work_step(work_reg[i-1]);
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                work_reg[i] <= work_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    assign finished = finish(work_reg[DATA_WIDTH-1]);
    assign buf_wr   = advance && valid_reg[DATA_WIDTH-1];
    assign buf_full = (bcount_reg == OCNT_FULL);
    assign empty    = (bcount_reg == '0);
    assign buf_rd   = pop && !empty;
    assign result   = buf_mem[brd_ptr_reg];

    always_comb
    begin
        bwr_ptr_next = bwr_ptr_reg;
        brd_ptr_next = brd_ptr_reg;
        bcount_next  = bcount_reg;
        if (buf_wr)
        begin
            bwr_ptr_next = (bwr_ptr_reg == OPTR_LAST) ? '0 : bwr_ptr_reg + 1'b1;
        end
        if (buf_rd)
        begin
            brd_ptr_next = (brd_ptr_reg == OPTR_LAST) ? '0 : brd_ptr_reg + 1'b1;
        end
        if (buf_wr && !buf_rd)
        begin
            bcount_next = bcount_reg + 1'b1;
        end
        else if (!buf_wr && buf_rd)
        begin
            bcount_next = bcount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bwr_ptr_reg <= '0;
            brd_ptr_reg <= '0;
            bcount_reg  <= '0;
        end
        else
        begin
            bwr_ptr_reg <= bwr_ptr_next;
            brd_ptr_reg <= brd_ptr_next;
            bcount_reg  <= bcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_wr)
        begin
            buf_mem[bwr_ptr_reg] <= finished;
        end
    end

endmodule

// File: rtl/signed_byte_alu_booth_divide_top.sv
// Top level of the signed byte ALU: front end, work queue and step pipeline.
// Depends on sbad_pkg, sbad_front, sbad_queue and sbad_back.

// The block takes one item per clock cycle while full is low and returns one
// result for each item, in order. An item enters when push is high and full
// is low; the result shows on result while empty is low and leaves when pop
// is high. Every operation runs through the same DATA_WIDTH-stage step
// pipeline (one Booth add/subtract-and-shift or one restoring divide step per
// stage). A four-item queue sits in front of the pipeline and a two-item
// buffer behind it; when pop stays low the pipeline holds, the queue fills
// and full rises. Add and subtract are done in the front end and ride the
// pipeline unchanged. Divide works on operand magnitudes and fixes signs on
// the way out: truncating quotient, remainder with the dividend's sign, a
// zero divisor gives zeros with overflow_flag set, and the most negative
// value over minus one wraps to the most negative value.

module signed_byte_alu_booth_divide_top
    import sbad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  alu_in_t  item,
    output logic     empty,
    input  logic     pop,
    output alu_out_t result
);

    logic  front_wr;
    work_t front_work;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_pop;
    work_t queue_head;

    // Classify the item and finish add/subtract.
    sbad_front u_front (
        .push       (push),
        .queue_full (queue_full),
        .item       (item),
        .wr_en      (front_wr),
        .work       (front_work)
    );

    // Decouple the front from pipeline stalls.
    sbad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_wr),
        .wr_data (front_work),
        .rd_en   (queue_pop),
        .rd_data (queue_head),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // Run the Booth and divide steps, buffer results for the consumer.
    sbad_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (queue_empty),
        .q_data  (queue_head),
        .q_pop   (queue_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign full = queue_full;

endmodule

// File: rtl/sbad_checker.sv
// Port-level checker for the signed byte ALU, bound to the top level.
// Depends on sbad_pkg for queue and pipeline capacity.

module sbad_checker
    import sbad_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     push,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input alu_out_t result
);

    logic [INFLIGHT_W-1:0] inflight_reg, inflight_next;
    logic                  in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!in_acc && out_acc)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Items held never exceed queue + pipeline + buffer.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INFLIGHT_W'(INFLIGHT_MAX))
        else $error("more items in flight than the block can hold");

    // No result without an outstanding item.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> inflight_reg != '0)
        else $error("result shown with no item outstanding");

    // Full only once the queue really holds its depth.
    a_full_honest: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> inflight_reg >= INFLIGHT_W'(QUEUE_DEPTH))
        else $error("full raised before the queue is filled");

    // A waiting result holds until taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

endmodule

bind signed_byte_alu_booth_divide_top sbad_checker u_sbad_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
